/* rtl/lia_pkg.sv */
// Shared types and constants for the LRU index allocator with expiry.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none
package lia_pkg;
   localparam int POOL_SIZE = 1024;
   localparam int IDX_W     = 10;
   localparam int LINK_W    = IDX_W + 1;
   localparam int TIME_W    = 63;
   localparam int ROW_W     = 32;
   localparam int ROWS      = POOL_SIZE / ROW_W;
   localparam int ROW_AW    = $clog2(ROWS);
   localparam int BIT_AW    = $clog2(ROW_W);
   localparam logic [LINK_W-1:0] SENT_LINK = LINK_W'(POOL_SIZE);

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_REJUV  = 2'd1;
   localparam logic [1:0] REQ_EXPIRE = 2'd2;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_REJUV  = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;
   localparam logic [1:0] OP_FAIL   = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [IDX_W-1:0]  entry_index;
      logic [TIME_W-1:0] now_time;
   } req_item_type;

   typedef struct packed {
      logic             success;
      logic [IDX_W-1:0] result_index;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] now;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;
endpackage
`default_nettype wire

/* rtl/lia_front.sv */
// Front end: accepts request transactions and classifies them into commands.
// Depends on lia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lia_front (
   input  wire lia_pkg::req_item_type    req_data,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire                           q_full,
   input  wire lia_pkg::back_status_type back_status,
   output logic                          push,
   output lia_pkg::cmd_type              push_data
);
   logic idx_in_pool;

   assign idx_in_pool = {1'b0, req_data.entry_index} < (lia_pkg::IDX_W + 1)'(lia_pkg::POOL_SIZE);
   assign req_ready   = !q_full && !back_status.clearing;
   assign push        = req_valid && req_ready;

   always_comb begin
      push_data.idx = req_data.entry_index;
      push_data.now = req_data.now_time;
      case (req_data.req_type)
         lia_pkg::REQ_ALLOC:  push_data.op = lia_pkg::OP_ALLOC;
         lia_pkg::REQ_REJUV:  push_data.op = idx_in_pool ? lia_pkg::OP_REJUV : lia_pkg::OP_FAIL;
         lia_pkg::REQ_EXPIRE: push_data.op = lia_pkg::OP_EXPIRE;
         default:             push_data.op = lia_pkg::OP_FAIL;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/lia_queue.sv */
// Two-entry command queue between front and back ends.
// Depends on lia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lia_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire lia_pkg::cmd_type push_data,
   input  wire                   pop,
   output logic                  full,
   output logic                  empty,
   output lia_pkg::cmd_type      head_data
);
   lia_pkg::cmd_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign empty     = cnt_ff == 2'd0;
   assign head_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

/* rtl/lia_back.sv */
// Back end: sequencer over the busy-bit, link and stamp memories.
// Depends on lia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lia_back (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           q_empty,
   input  wire lia_pkg::cmd_type         q_data,
   output logic                          pop,
   output lia_pkg::back_status_type      back_status,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output lia_pkg::rsp_item_type         rsp_data
);
   localparam int IW = lia_pkg::IDX_W;
   localparam int LW = lia_pkg::LINK_W;
   localparam int RA = lia_pkg::ROW_AW;
   localparam int BA = lia_pkg::BIT_AW;
   localparam int RW = lia_pkg::ROW_W;
   localparam int TW = lia_pkg::TIME_W;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_AL_W1  = 4'd3;
   localparam logic [3:0] S_AL_W2  = 4'd4;
   localparam logic [3:0] S_RJ_CHK = 4'd5;
   localparam logic [3:0] S_RJ_W2  = 4'd6;
   localparam logic [3:0] S_RJ_W3  = 4'd7;
   localparam logic [3:0] S_EX_CHK = 4'd8;

   // memories
   logic [RW-1:0] busy_mem  [lia_pkg::ROWS];
   logic [LW-1:0] prev_mem  [lia_pkg::POOL_SIZE];
   logic [LW-1:0] next_mem  [lia_pkg::POOL_SIZE];
   logic [TW-1:0] stamp_mem [lia_pkg::POOL_SIZE];
   logic [RW-1:0] busy_rd_ff;
   logic [LW-1:0] prev_rd_ff, next_rd_ff;
   logic [TW-1:0] stamp_rd_ff;

   logic          busy_re, busy_we, link_re, prev_we, next_we, stamp_re, stamp_we;
   logic [RA-1:0] busy_ra, busy_wa;
   logic [RW-1:0] busy_wd;
   logic [IW-1:0] link_ra, prev_wa, next_wa, stamp_ra, stamp_wa;
   logic [LW-1:0] prev_wd, next_wd;

   logic [3:0]      state_ff, state_in;
   lia_pkg::cmd_type cmd_ff, cmd_in;
   logic [RA-1:0]   row_ff, row_in, clr_ff, clr_in;
   logic [RA:0]     scan_ff, scan_in;
   logic [IW-1:0]   f_ff, f_in, head_ff, head_in, tail_ff, tail_in, ss_ff, ss_in;
   logic            head_v_ff, head_v_in, tail_v_ff, tail_v_in;
   logic [LW-1:0]   pp_ff, pp_in, pn_ff, pn_in;
   logic            rsp_valid_ff, rsp_valid_in;
   lia_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic            load;
   logic [RW-1:0]   cand;
   logic            found;
   logic [BA-1:0]   enc;
   logic [IW-1:0]   f_now;
   logic [RA-1:0]   row_next;

   assign back_status.clearing = state_ff == S_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign row_next  = (row_ff == RA'(lia_pkg::ROWS - 1)) ? '0 : row_ff + 1'b1;

   // free candidates in the scanned row; first and wrap-around passes are masked
   always_comb begin
      cand = ~busy_rd_ff;
      for (int b = 0; b < RW; b++) begin
         if (scan_ff == '0 && BA'(b) < ss_ff[BA-1:0]) cand[b] = 1'b0;
         if (scan_ff == (RA + 1)'(lia_pkg::ROWS) && BA'(b) >= ss_ff[BA-1:0]) cand[b] = 1'b0;
      end
      found = |cand;
      enc   = '0;
      for (int b = RW - 1; b >= 0; b--) begin
         if (cand[b]) enc = BA'(b);
      end
      f_now = {row_ff, enc};
   end

   always_comb begin
      state_in = state_ff;  cmd_in = cmd_ff;  row_in = row_ff;  clr_in = clr_ff;
      scan_in = scan_ff;    f_in = f_ff;      head_in = head_ff; tail_in = tail_ff;
      ss_in = ss_ff;        head_v_in = head_v_ff; tail_v_in = tail_v_ff;
      pp_in = pp_ff;        pn_in = pn_ff;
      rsp_data_in = rsp_data_ff;
      load = 1'b0;  pop = 1'b0;
      busy_re = 1'b0; busy_we = 1'b0; link_re = 1'b0; prev_we = 1'b0; next_we = 1'b0;
      stamp_re = 1'b0; stamp_we = 1'b0;
      busy_ra = '0; busy_wa = '0; busy_wd = '0; link_ra = '0; prev_wa = '0; next_wa = '0;
      stamp_ra = '0; stamp_wa = '0; prev_wd = '0; next_wd = '0;
      case (state_ff)
         S_CLEAR: begin
            busy_we = 1'b1;
            busy_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == RA'(lia_pkg::ROWS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!q_empty && !rsp_valid_ff) begin
               pop    = 1'b1;
               cmd_in = q_data;
               case (q_data.op)
                  lia_pkg::OP_ALLOC: begin
                     row_in   = ss_ff[IW-1:BA];
                     scan_in  = '0;
                     busy_re  = 1'b1;
                     busy_ra  = ss_ff[IW-1:BA];
                     state_in = S_SCAN;
                  end
                  lia_pkg::OP_REJUV: begin
                     busy_re  = 1'b1;
                     busy_ra  = q_data.idx[IW-1:BA];
                     link_re  = 1'b1;
                     link_ra  = q_data.idx;
                     state_in = S_RJ_CHK;
                  end
                  lia_pkg::OP_EXPIRE: begin
                     if (tail_v_ff) begin
                        busy_re  = 1'b1;
                        busy_ra  = tail_ff[IW-1:BA];
                        link_re  = 1'b1;
                        link_ra  = tail_ff;
                        stamp_re = 1'b1;
                        stamp_ra = tail_ff;
                        state_in = S_EX_CHK;
                     end else begin
                        load = 1'b1;
                        rsp_data_in = '0;
                     end
                  end
                  default: begin
                     load = 1'b1;
                     rsp_data_in = '0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (found) begin
               f_in     = f_now;
               state_in = S_AL_W1;
            end else if (scan_ff == (RA + 1)'(lia_pkg::ROWS)) begin
               load = 1'b1;
               rsp_data_in = '0;
               state_in = S_IDLE;
            end else begin
               row_in  = row_next;
               scan_in = scan_ff + 1'b1;
               busy_re = 1'b1;
               busy_ra = row_next;
            end
         end
         S_AL_W1: begin
            busy_we  = 1'b1;
            busy_wa  = f_ff[IW-1:BA];
            busy_wd  = busy_rd_ff | (RW'(1) << f_ff[BA-1:0]);
            next_we  = 1'b1;
            next_wa  = f_ff;
            next_wd  = head_v_ff ? {1'b0, head_ff} : lia_pkg::SENT_LINK;
            prev_we  = 1'b1;
            prev_wa  = f_ff;
            prev_wd  = lia_pkg::SENT_LINK;
            stamp_we = 1'b1;
            stamp_wa = f_ff;
            ss_in    = (f_ff == IW'(lia_pkg::POOL_SIZE - 1)) ? '0 : f_ff + 1'b1;
            if (head_v_ff) begin
               state_in = S_AL_W2;
            end else begin
               head_in = f_ff;  head_v_in = 1'b1;
               tail_in = f_ff;  tail_v_in = 1'b1;
               load = 1'b1;
               rsp_data_in = '{success: 1'b1, result_index: f_ff};
               state_in = S_IDLE;
            end
         end
         S_AL_W2: begin
            prev_we  = 1'b1;
            prev_wa  = head_ff;
            prev_wd  = {1'b0, f_ff};
            head_in  = f_ff;
            load     = 1'b1;
            rsp_data_in = '{success: 1'b1, result_index: f_ff};
            state_in = S_IDLE;
         end
         S_RJ_CHK: begin
            if (!busy_rd_ff[cmd_ff.idx[BA-1:0]]) begin
               load = 1'b1;
               rsp_data_in = '0;
               state_in = S_IDLE;
            end else begin
               stamp_we = 1'b1;
               stamp_wa = cmd_ff.idx;
               pp_in    = prev_rd_ff;
               pn_in    = next_rd_ff;
               if (head_ff == cmd_ff.idx) begin
                  load = 1'b1;
                  rsp_data_in = '{success: 1'b1, result_index: '0};
                  state_in = S_IDLE;
               end else begin
                  prev_we  = 1'b1;
                  prev_wa  = cmd_ff.idx;
                  prev_wd  = lia_pkg::SENT_LINK;
                  next_we  = 1'b1;
                  next_wa  = cmd_ff.idx;
                  next_wd  = {1'b0, head_ff};
                  state_in = S_RJ_W2;
               end
            end
         end
         S_RJ_W2: begin
            // unlink: the entry is not the head, so its predecessor is a pool cell
            next_we = 1'b1;
            next_wa = pp_ff[IW-1:0];
            next_wd = pn_ff;
            if (pn_ff == lia_pkg::SENT_LINK) begin
               tail_in = pp_ff[IW-1:0];
            end else begin
               prev_we = 1'b1;
               prev_wa = pn_ff[IW-1:0];
               prev_wd = pp_ff;
            end
            state_in = S_RJ_W3;
         end
         S_RJ_W3: begin
            prev_we  = 1'b1;
            prev_wa  = head_ff;
            prev_wd  = {1'b0, cmd_ff.idx};
            head_in  = cmd_ff.idx;
            load     = 1'b1;
            rsp_data_in = '{success: 1'b1, result_index: '0};
            state_in = S_IDLE;
         end
         S_EX_CHK: begin
            load     = 1'b1;
            state_in = S_IDLE;
            if (stamp_rd_ff > cmd_ff.now) begin
               rsp_data_in = '0;
            end else begin
               busy_we = 1'b1;
               busy_wa = tail_ff[IW-1:BA];
               busy_wd = busy_rd_ff & ~(RW'(1) << tail_ff[BA-1:0]);
               if (prev_rd_ff != lia_pkg::SENT_LINK) begin
                  next_we = 1'b1;
                  next_wa = prev_rd_ff[IW-1:0];
                  next_wd = lia_pkg::SENT_LINK;
                  tail_in = prev_rd_ff[IW-1:0];
               end else begin
                  head_v_in = 1'b0;
                  tail_v_in = 1'b0;
               end
               rsp_data_in = '{success: 1'b1, result_index: tail_ff};
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ss_ff        <= '0;
         head_v_ff    <= 1'b0;
         tail_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ss_ff        <= ss_in;
         head_v_ff    <= head_v_in;
         tail_v_ff    <= tail_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      scan_ff     <= scan_in;
      f_ff        <= f_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      pp_ff       <= pp_in;
      pn_ff       <= pn_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (busy_we) busy_mem[busy_wa] <= busy_wd;
      if (busy_re) busy_rd_ff <= busy_mem[busy_ra];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (link_re) prev_rd_ff <= prev_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (link_re) next_rd_ff <= next_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (stamp_we) stamp_mem[stamp_wa] <= cmd_ff.now;
      if (stamp_re) stamp_rd_ff <= stamp_mem[stamp_ra];
   end

   a_ends_agree: assert property (@(posedge clock) disable iff (reset)
      head_v_ff == tail_v_ff)
      else $error("head and tail validity disagree");
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !pop)
      else $error("command popped during clearing pass");
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid_ff)
      else $error("response overwritten before it was taken");
endmodule
`default_nettype wire

/* rtl/lru_index_allocator_with_expiry.sv */
// Top level of the LRU index allocator with expiry.
// Depends on lia_pkg, lia_front, lia_queue and lia_back.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) carries one request transaction:
//    allocate, rejuvenate an index, or expire the oldest entry.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one response
//    transaction per request, in request order.
//  - Requests enter a two-entry command queue; the back end runs one command
//    at a time over the busy-bit rows, the link memories and the stamp memory.
//  - The free search reads one 32-bit busy row per cycle, up to ROWS + 1 rows.
//  - The back end takes the next command only once the previous response has
//    left the output register.
//  - After reset a clearing pass over all ROWS busy rows (32 at the default pool
//    size) zeroes them; req_ready stays low during it.
//  - A pending response sits in an output register; while rsp_ready is low the
//    queue keeps accepting until it fills, then req_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module lru_index_allocator_with_expiry (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire lia_pkg::req_item_type  req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output lia_pkg::rsp_item_type       rsp_data
);
   logic                     push, pop, q_full, q_empty;
   lia_pkg::cmd_type         push_data, q_data;
   lia_pkg::back_status_type back_status;

   // classify and accept
   lia_front u_front (
      .req_data    (req_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .q_full      (q_full),
      .back_status (back_status),
      .push        (push),
      .push_data   (push_data)
   );

   // decouples acceptance from execution
   lia_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_data (q_data)
   );

   // list and pool maintenance, response register
   lia_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .pop         (pop),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );
endmodule
`default_nettype wire

/* tb/lru_index_allocator_with_expiry_checker.sv */
// Checker for the LRU index allocator with expiry: watches both channels,
// predicts every response from its own model of the pool, compares in order.
// Depends on lia_pkg.
`timescale 1ns / 1ps
module lru_index_allocator_with_expiry_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  wire                        req_ready,
   input  wire lia_pkg::req_item_type req_data,
   input  wire                        rsp_valid,
   input  wire                        rsp_ready,
   input  wire lia_pkg::rsp_item_type rsp_data,
   output int                         fail_count,
   output int                         pending_count,
   output int                         granted_count
);
   localparam int CELLS = lia_pkg::POOL_SIZE + 1;
   localparam logic [31:0] NO_LINK = 32'hFFFF_FFFF;

   logic [31:0] back_of [CELLS];
   logic [31:0] fwd_of [CELLS];
   logic [63:0] stamp_of [lia_pkg::POOL_SIZE];
   bit          held [CELLS];
   int unsigned scan_from;
   lia_pkg::rsp_item_type answers [$];

   function automatic bit is_cell(logic [31:0] l);
      return l < CELLS;
   endfunction

   task automatic clear_pool();
      for (int i = 0; i < CELLS; i++) begin
         back_of[i] = NO_LINK;
         fwd_of[i]  = NO_LINK;
         held[i]    = 0;
      end
      for (int i = 0; i < lia_pkg::POOL_SIZE; i++) stamp_of[i] = '1;
      held[lia_pkg::POOL_SIZE] = 1;
      scan_from = 0;
   endtask

   function automatic lia_pkg::rsp_item_type serve_request(lia_pkg::req_item_type r);
      lia_pkg::rsp_item_type o;
      logic [31:0] f, first, pp, pn, old;
      logic [31:0] idx;
      logic [63:0] now;
      o = '0;
      idx = 32'(r.entry_index);
      now = 64'(r.now_time);
      case (r.req_type)
         lia_pkg::REQ_ALLOC: begin
            f = NO_LINK;
            for (int i = 0; i < lia_pkg::POOL_SIZE; i++) begin
               int unsigned c;
               c = (scan_from + i) % lia_pkg::POOL_SIZE;
               if (!held[c]) begin
                  f = c;
                  break;
               end
            end
            if (f != NO_LINK) begin
               first = fwd_of[lia_pkg::POOL_SIZE];
               if (is_cell(first)) begin
                  back_of[first] = f;
                  fwd_of[f] = first;
               end else begin
                  back_of[lia_pkg::POOL_SIZE] = f;
                  fwd_of[f] = lia_pkg::POOL_SIZE;
               end
               fwd_of[lia_pkg::POOL_SIZE] = f;
               back_of[f] = lia_pkg::POOL_SIZE;
               stamp_of[f] = now;
               held[f] = 1;
               scan_from = (f + 1) % lia_pkg::POOL_SIZE;
               o.success = 1;
               o.result_index = f[lia_pkg::IDX_W-1:0];
            end
         end
         lia_pkg::REQ_REJUV: begin
            if (idx < lia_pkg::POOL_SIZE && held[idx]) begin
               pp = back_of[idx];
               pn = fwd_of[idx];
               first = fwd_of[lia_pkg::POOL_SIZE];
               stamp_of[idx] = now;
               if (first != idx && is_cell(pp) && is_cell(pn) && is_cell(first)) begin
                  fwd_of[lia_pkg::POOL_SIZE] = idx;
                  back_of[idx] = lia_pkg::POOL_SIZE;
                  fwd_of[idx] = first;
                  fwd_of[pp] = pn;
                  back_of[pn] = pp;
                  back_of[first] = idx;
               end
               o.success = 1;
            end
         end
         lia_pkg::REQ_EXPIRE: begin
            old = back_of[lia_pkg::POOL_SIZE];
            // stamps compare as signed 64-bit
            if (old < lia_pkg::POOL_SIZE && !($signed(stamp_of[old]) > $signed(now))) begin
               pp = back_of[old];
               if (pp != lia_pkg::POOL_SIZE) begin
                  if (is_cell(pp)) begin
                     fwd_of[pp] = lia_pkg::POOL_SIZE;
                     back_of[lia_pkg::POOL_SIZE] = pp;
                  end
               end else begin
                  back_of[lia_pkg::POOL_SIZE] = NO_LINK;
                  fwd_of[lia_pkg::POOL_SIZE] = NO_LINK;
               end
               held[old] = 0;
               o.success = 1;
               o.result_index = old[lia_pkg::IDX_W-1:0];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   assign pending_count = answers.size();

   always @(posedge clock) begin
      lia_pkg::rsp_item_type want;
      if (reset) begin
         clear_pool();
         answers.delete();
         fail_count <= 0;
         granted_count <= 0;
      end else begin
         if (req_valid && req_ready) answers.push_back(serve_request(req_data));
         if (rsp_valid && rsp_ready) begin
            if (answers.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected response: success=%0d index=%0d",
                           rsp_data.success, rsp_data.result_index);
            end else begin
               want = answers.pop_front();
               if (want.success && want.result_index != 0)
                  granted_count <= granted_count + 1;
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected success=%0d index=%0d, got %0d %0d",
                              want.success, want.result_index,
                              rsp_data.success, rsp_data.result_index);
               end
            end
         end
      end
   end
endmodule

/* tb/lru_index_allocator_with_expiry_test.sv */
// Top of the LRU index allocator testbench: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on lia_pkg, the block and the checker.
`timescale 1ns / 1ps
module lru_index_allocator_with_expiry_test;
   localparam int WATCH_LIMIT = 20000;
   localparam int FILL_COUNT  = 200;
   localparam int DIRECT_LEN  = 400;
   localparam logic [1:0] REQ_BAD = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic rsp_ready = 0;
   lia_pkg::req_item_type req_data = '0;
   wire req_ready, rsp_valid;
   lia_pkg::rsp_item_type rsp_data;
   int fail_count, pending_count, granted_count;
   bit stim_done = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;
   int sent = 0;
   logic [62:0] clock_us = 0;

   lru_index_allocator_with_expiry dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   lru_index_allocator_with_expiry_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .granted_count(granted_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Send one transaction, then wait for the handshake.
   // req_ready only moves at the rising edge, so it is sampled mid-cycle.
   task automatic send(logic [1:0] t, logic [9:0] idx, logic [62:0] now);
      req_valid <= 1;
      req_data  <= '{req_type: t, entry_index: idx, now_time: now};
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sent++;
   endtask

   task automatic send_gap(logic [1:0] t, logic [9:0] idx, logic [62:0] now);
      int gap;
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      send(t, idx, now);
   endtask

   // Stimulus: directed corner cases, then mostly coherent random traffic.
   initial begin
      int pick;
      logic [62:0] tm;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // empty list expire, free index rejuvenate, unknown type
      send(lia_pkg::REQ_EXPIRE, 0, '1);
      send(lia_pkg::REQ_REJUV, 10'd1023, 0);
      send(REQ_BAD, 10'd5, '1);
      send(lia_pkg::REQ_ALLOC, 0, 0);
      send(lia_pkg::REQ_REJUV, 0, 63'd5);        // index already at head: restamp only
      send(lia_pkg::REQ_ALLOC, 10'h3FF, '1);
      send(lia_pkg::REQ_ALLOC, 0, 63'd100);
      send(lia_pkg::REQ_REJUV, 0, 63'd7);        // move tail to head
      send(lia_pkg::REQ_EXPIRE, 0, 63'd3);       // fresh oldest
      send(lia_pkg::REQ_EXPIRE, 0, '1);
      send(lia_pkg::REQ_EXPIRE, 0, 63'd100);
      send(lia_pkg::REQ_EXPIRE, 0, '1);          // last entry: list empties
      send(lia_pkg::REQ_EXPIRE, 0, '1);
      // big time stamps still compare as unsigned, above small ones
      send(lia_pkg::REQ_ALLOC, 0, {1'b1, 62'd0});
      send(lia_pkg::REQ_EXPIRE, 0, 63'd0);
      send(lia_pkg::REQ_EXPIRE, 0, '1);
      // fill part of the pool back to back, then drain most of it
      for (int i = 0; i < FILL_COUNT; i++) send(lia_pkg::REQ_ALLOC, 10'(i), 63'(i));
      send(lia_pkg::REQ_ALLOC, 0, 0);
      for (int i = 0; i < FILL_COUNT - 8; i++) send(lia_pkg::REQ_EXPIRE, 0, '1);
      // random part: time mostly advancing, rejuvenate indices mostly from 0 to 40
      for (int n = 0; n < 300; n++) begin
         pick = $urandom_range(0, 99);
         clock_us = clock_us + 63'($urandom_range(0, 40));
         tm = ($urandom_range(0, 19) == 0) ? 63'({$urandom, $urandom}) : clock_us;
         if (pick < 40) send_gap(lia_pkg::REQ_ALLOC, 10'($urandom), tm);
         else if (pick < 70)
            send_gap(lia_pkg::REQ_REJUV, ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                         : 10'($urandom_range(0, 40)), tm);
         else if (pick < 96)
            send_gap(lia_pkg::REQ_EXPIRE, 10'($urandom),
                     clock_us - 63'($urandom_range(0, 200)));
         else send_gap(REQ_BAD, 10'($urandom), tm);
      end
      req_valid <= 0;
      stim_done <= 1;
   end

   // Receiver: random ready gaps; one long hold-off to fill the queue.
   initial begin
      @(negedge reset);
      repeat (40) @(posedge clock);
      hold_rsp <= 1;
      repeat (300) @(posedge clock);
      hold_rsp <= 0;
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (sent < DIRECT_LEN) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= !hold_rsp;
         @(negedge clock);
         while (!(rsp_valid && rsp_ready)) begin
            @(posedge clock);
            rsp_ready <= !hold_rsp;
            @(negedge clock);
         end
         @(posedge clock);
      end
   end

   // Watchdog on cycles with no accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      @(posedge stim_done);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d requests: empty pool, fresh and stale expiry,", sent);
      $display("rejuvenation of head, tail and free indices; %0d nonzero grants.",
               granted_count);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
